[rtl/slefp_pkg.sv]
// ---------------------------------------------------------------------------
// slefp_pkg
// Shared types and constants of the start/length/end frame parser.
// ---------------------------------------------------------------------------
package slefp_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Largest length the 5-bit length fields can carry.
    localparam int LEN_FIELD_MAX = 31;

    // Default payload store depth.
    localparam int MAX_PAYLOAD_DEF = 31;

    // Output tdata: payload_byte, byte_index, frame_length, padded to bytes.
    localparam int OUT_FIELDS_W = BYTE_W + LEN_W + LEN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd35;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd255;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST = 5'd19;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cnt_clr;        // clear the byte counter
        logic cnt_inc;        // advance the byte counter
        logic len_load;       // take the length from the input byte
        logic mem_wr;         // store the input byte at the counter
        logic out_load_mem;   // load the output register from the store
        logic out_load_empty; // load the output register with an empty frame
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_hit;  // input byte equals the start marker
        logic end_hit;    // input byte equals the end marker
        logic len_ok;     // input byte is an acceptable length
        logic len_in_zero;// input byte is zero
        logic len_zero;   // stored length is zero
        logic count_done; // the byte being stored is the last of the payload
        logic out_taken;  // output item accepted this cycle
        logic out_last;   // output register holds the last item of a frame
    } dp_status_t;

endpackage

[rtl/slefp_ctrl.sv]
// ---------------------------------------------------------------------------
// slefp_ctrl
// Frame parsing state machine; drives the datapath through commands.
// ---------------------------------------------------------------------------
module slefp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  slefp_pkg::dp_status_t status,
    output slefp_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_LEN,
        S_DATA,
        S_END,
        S_READ,
        S_SHOW,
        S_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc;

    assign in_ready = (state_reg == S_HUNT) || (state_reg == S_LEN) ||
                      (state_reg == S_DATA) || (state_reg == S_END);
    assign acc = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_HUNT:
            begin
                if (acc && status.start_hit)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_LEN;
                end
            end
            S_LEN:
            begin
                if (acc && status.len_ok)
                begin
                    cmd.len_load = 1'b1;
                    cmd.cnt_clr  = 1'b1;
                    state_next   = status.len_in_zero ? S_END : S_DATA;
                end
            end
            S_DATA:
            begin
                if (acc)
                begin
                    cmd.mem_wr  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (status.count_done)
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_END:
            begin
                if (acc)
                begin
                    cmd.cnt_clr = 1'b1;
                    if (!status.end_hit)
                    begin
                        state_next = S_HUNT;
                    end
                    else if (status.len_zero)
                    begin
                        cmd.out_load_empty = 1'b1;
                        state_next         = S_WAIT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // The store's registered read port captures the entry here.
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                cmd.out_load_mem = 1'b1;
                state_next       = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.out_taken)
                begin
                    if (status.out_last)
                    begin
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/slefp_datapath.sv]
// ---------------------------------------------------------------------------
// slefp_datapath
// Configuration registers, byte counter, payload store and output register.
// ---------------------------------------------------------------------------
module slefp_datapath
#(
    parameter int MAX_PAYLOAD = slefp_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [slefp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slefp_pkg::BYTE_W-1:0]        cfg_data,
    input  logic [slefp_pkg::BYTE_W-1:0]        rx_byte,
    input  slefp_pkg::ctrl_cmd_t                cmd,
    output slefp_pkg::dp_status_t               status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [slefp_pkg::OUT_TDATA_W-1:0]   out_data,
    output logic                                out_last
);

    // Lengths never exceed the 5-bit field, so deeper storage is never used.
    localparam int STORE_DEPTH = (MAX_PAYLOAD > slefp_pkg::LEN_FIELD_MAX) ?
                                 slefp_pkg::LEN_FIELD_MAX : MAX_PAYLOAD;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PAD_W       = slefp_pkg::OUT_TDATA_W - slefp_pkg::OUT_FIELDS_W;

    logic [slefp_pkg::BYTE_W-1:0] start_marker_reg;
    logic [slefp_pkg::BYTE_W-1:0] end_marker_reg;
    logic [slefp_pkg::LEN_W-1:0]  length_limit_reg;

    logic [slefp_pkg::LEN_W-1:0]  count_reg;
    logic [slefp_pkg::LEN_W-1:0]  exp_len_reg;
    logic [slefp_pkg::BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic [slefp_pkg::BYTE_W-1:0] rd_data_reg;

    logic                         out_valid_reg;
    logic [slefp_pkg::BYTE_W-1:0] out_byte_reg;
    logic [slefp_pkg::LEN_W-1:0]  out_index_reg;
    logic [slefp_pkg::LEN_W-1:0]  out_len_reg;
    logic                         out_last_reg;

    logic [slefp_pkg::LEN_W:0]    count_plus;
    logic [ADDR_W-1:0]            addr;

    assign count_plus = {1'b0, count_reg} + {{slefp_pkg::LEN_W{1'b0}}, 1'b1};
    assign addr       = count_reg[ADDR_W-1:0];

    assign status.start_hit   = (rx_byte == start_marker_reg);
    assign status.end_hit     = (rx_byte == end_marker_reg);
    assign status.len_ok      = (rx_byte <= {3'b000, length_limit_reg}) &&
                                ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD));
    assign status.len_in_zero = (rx_byte == '0);
    assign status.len_zero    = (exp_len_reg == '0);
    assign status.count_done  = (count_plus >= {1'b0, exp_len_reg});
    assign status.out_taken   = out_valid_reg && out_ready;
    assign status.out_last    = out_last_reg;

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {{PAD_W{1'b0}}, out_len_reg, out_index_reg, out_byte_reg};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= slefp_pkg::START_MARKER_RST;
            end_marker_reg   <= slefp_pkg::END_MARKER_RST;
            length_limit_reg <= slefp_pkg::LENGTH_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                slefp_pkg::REG_START_MARKER: start_marker_reg <= cfg_data;
                slefp_pkg::REG_END_MARKER:   end_marker_reg   <= cfg_data;
                slefp_pkg::REG_LENGTH_LIMIT:
                    length_limit_reg <= cfg_data[slefp_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Counter, length and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            exp_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_plus[slefp_pkg::LEN_W-1:0];
            end
            if (cmd.len_load)
            begin
                exp_len_reg <= rx_byte[slefp_pkg::LEN_W-1:0];
            end
            if (cmd.out_load_mem || cmd.out_load_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload store with a registered read port at the counter.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            store_mem[addr] <= rx_byte;
        end
        rd_data_reg <= store_mem[addr];
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_mem)
        begin
            out_byte_reg  <= rd_data_reg;
            out_index_reg <= count_reg;
            out_len_reg   <= exp_len_reg;
            out_last_reg  <= (count_plus == {1'b0, exp_len_reg});
        end
        else if (cmd.out_load_empty)
        begin
            out_byte_reg  <= '0;
            out_index_reg <= '0;
            out_len_reg   <= '0;
            out_last_reg  <= 1'b1;
        end
    end

endmodule

[rtl/start_length_end_frame_parser_top.sv]
// ---------------------------------------------------------------------------
// start_length_end_frame_parser_top
// Deframer for start marker / length / payload / end marker byte streams.
// ---------------------------------------------------------------------------
// The block takes one received byte per item on the slave stream and hunts
// for the start marker. The byte after it is the payload length; a length
// above length_limit (or above the store depth) is skipped and the block
// keeps waiting for an acceptable one. That many payload bytes are stored,
// then the next byte must equal the end marker. On a match the stored bytes
// leave on the master stream in order, each carrying its index and the frame
// length, with tlast on the final one; an empty frame yields a single item
// with all fields zero and tlast set. A wrong end marker drops the frame.
// While parsing, the input is always ready. During emission no input is
// taken: each result is a store read, an output load and a hand-over that
// waits while the sink holds tready low; the store's single registered read
// port is used again only once the item is taken. Configuration writes are
// always accepted and should be made while the block is idle.
module start_length_end_frame_parser_top
#(
    parameter int MAX_PAYLOAD = slefp_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream. s_tdata: rx_byte [7:0].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [slefp_pkg::BYTE_W-1:0]        s_tdata,
    // Output stream. m_tdata: payload_byte [7:0], byte_index [12:8],
    // frame_length [17:13], zero padding above. m_tlast: last.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [slefp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                m_tlast,
    // Configuration writes: 0 start_marker, 1 end_marker, 2 length_limit.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slefp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slefp_pkg::BYTE_W-1:0]        cfg_data
);

    slefp_pkg::ctrl_cmd_t  cmd;
    slefp_pkg::dp_status_t status;

    // Register writes are always accepted.
    assign cfg_ready = 1'b1;

    slefp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slefp_datapath
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

[tb/sv/start_length_end_frame_parser_top_tb.sv]
// ---------------------------------------------------------------------------
// start_length_end_frame_parser_top_tb
// Self-checking bench for the start/length/end frame parser.
// ---------------------------------------------------------------------------
// Received bytes are queued up front and sent on the input stream by a
// clocked driver. As each item is accepted, a behavioral copy of the parser
// works out which payload bytes the block must emit. A clocked monitor
// compares every output item, field by field, with the oldest of those.
// Both streams idle at random between items. The run covers several register
// settings, with the extremes among them, and changes them only while idle.
// ---------------------------------------------------------------------------
module start_length_end_frame_parser_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W    = slefp_pkg::BYTE_W;
    localparam int LEN_W     = slefp_pkg::LEN_W;
    localparam int CFG_IDX_W = slefp_pkg::CFG_IDX_W;

    // Register index with no register behind it; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 9;
    // An item that leaves no result may still be in flight when the last
    // expected result is seen; the settle wait covers the parser's pipeline.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;

    typedef enum logic [1:0] {
        HUNT_START,
        AWAIT_LEN,
        TAKE_PAYLOAD,
        CHECK_END
    } parse_phase_t;

    // One output item, the way the monitor rebuilds it from the ports.
    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic [LEN_W-1:0]  index;
        logic [LEN_W-1:0]  length;
        logic              last;
    } frame_item_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [BYTE_W-1:0]                 s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [slefp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                              m_tlast;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [CFG_IDX_W-1:0]              cfg_index = '0;
    logic [BYTE_W-1:0]                 cfg_data  = '0;

    start_length_end_frame_parser_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bytes waiting to be sent, and payload items the block still owes us.
    logic [BYTE_W-1:0] rx_pending[$];
    frame_item_t       frame_bytes_due[$];

    // Shadow copy of the parser: registers, phase, counters and store.
    logic [BYTE_W-1:0] cfg_start = slefp_pkg::START_MARKER_RST;
    logic [BYTE_W-1:0] cfg_end   = slefp_pkg::END_MARKER_RST;
    logic [LEN_W-1:0]  cfg_limit = slefp_pkg::LENGTH_LIMIT_RST;
    parse_phase_t      phase     = HUNT_START;
    int                fill      = 0;
    int                want_len  = 0;
    logic [BYTE_W-1:0] store [slefp_pkg::MAX_PAYLOAD_DEF];

    int mismatches = 0;
    int cycle_count = 0;
    int stim_count = 0;
    int rx_gap = 0;
    int res_gap = 0;

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Every so often both sides run without idling for a stretch, so that
    // back-to-back traffic is seen as well as ragged traffic.
    function automatic int draw_wait();
        if ((cycle_count % 600) < 120)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    // Advances the shadow parser by one accepted byte. A matching end marker
    // queues the whole stored payload, or a single zero item for an empty
    // frame.
    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        frame_item_t r;
        int          i;
        case (phase)
            HUNT_START:
            begin
                if (b == cfg_start)
                begin
                    phase = AWAIT_LEN;
                    fill  = 0;
                end
            end
            AWAIT_LEN:
            begin
                // Too long a length is skipped; the next byte is tried instead.
                if (b <= cfg_limit && b <= slefp_pkg::MAX_PAYLOAD_DEF)
                begin
                    want_len = int'(b);
                    fill     = 0;
                    phase    = (want_len == 0) ? CHECK_END : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD:
            begin
                if (fill < slefp_pkg::MAX_PAYLOAD_DEF && fill < want_len)
                begin
                    store[fill] = b;
                    fill++;
                end
                if (fill >= want_len || fill >= slefp_pkg::MAX_PAYLOAD_DEF)
                    phase = CHECK_END;
            end
            default:
            begin
                if (b == cfg_end)
                begin
                    if (want_len == 0)
                    begin
                        r = '{payload: '0, index: '0, length: '0, last: 1'b1};
                        frame_bytes_due.push_back(r);
                    end
                    else
                    begin
                        for (i = 0; i < want_len && i < slefp_pkg::MAX_PAYLOAD_DEF; i++)
                        begin
                            r.payload = store[i];
                            r.index   = LEN_W'(i);
                            r.length  = LEN_W'(want_len);
                            r.last    = (i + 1 == want_len);
                            frame_bytes_due.push_back(r);
                        end
                    end
                end
                phase = HUNT_START;
                fill  = 0;
            end
        endcase
    endtask

    // Input driver. The prediction is made on the edge where the item is
    // taken, then a fresh wait is drawn before the next byte goes out.
    always @(posedge clk or negedge rst_n)
    begin : rx_driver
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            rx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_rx_byte(s_tdata);
                rx_gap = draw_wait();
            end
            if (!s_tvalid || s_tready)
            begin
                if (rx_gap > 0)
                begin
                    rx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (rx_pending.size() != 0)
                begin
                    s_tdata  <= rx_pending.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and sink. After each item taken, a random wait is drawn
    // and tready is held low until it runs out; the wait may be zero.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        frame_item_t got;
        frame_item_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            res_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.payload = m_tdata[BYTE_W-1:0];
                got.index   = m_tdata[BYTE_W +: LEN_W];
                got.length  = m_tdata[BYTE_W+LEN_W +: LEN_W];
                got.last    = m_tlast;
                if (frame_bytes_due.size() == 0)
                begin
                    flag_error($sformatf(
                        "unexpected item byte=%02h idx=%0d len=%0d last=%0b",
                        got.payload, got.index, got.length, got.last));
                end
                else
                begin
                    want = frame_bytes_due.pop_front();
                    // The padding above the fields must stay zero as well.
                    if (got !== want ||
                        m_tdata[slefp_pkg::OUT_TDATA_W-1:slefp_pkg::OUT_FIELDS_W] !== '0)
                    begin
                        flag_error($sformatf({"item mismatch: expected byte=%02h idx=%0d ",
                            "len=%0d last=%0b, got byte=%02h idx=%0d len=%0d last=%0b ",
                            "tdata=%06h"},
                            want.payload, want.index, want.length, want.last,
                            got.payload, got.index, got.length, got.last, m_tdata));
                    end
                end
                res_gap = draw_wait();
            end
            if (res_gap > 0)
            begin
                res_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_rx(input logic [BYTE_W-1:0] b);
        rx_pending.push_back(b);
        stim_count++;
    endtask

    // Writes one register and mirrors it into the shadow parser on the edge
    // the write is taken. Unused indexes change nothing.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            slefp_pkg::REG_START_MARKER: cfg_start = val;
            slefp_pkg::REG_END_MARKER:   cfg_end   = val;
            slefp_pkg::REG_LENGTH_LIMIT: cfg_limit = val[LEN_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Holds off until everything queued has been sent and every expected
    // item has come back, then lets the parser settle.
    task automatic wait_idle();
        do @(posedge clk);
        while (rx_pending.size() != 0 || s_tvalid || frame_bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Queues one frame built for the current registers. Most are well formed
    // with random payload; some carry a skipped length or a bad end marker,
    // and a few are plain noise that can land the parser anywhere.
    task automatic queue_frame();
        int pick;
        int len;
        int short_cap;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            repeat ($urandom_range(1, 6)) push_rx(BYTE_W'($urandom));
        end
        else
        begin
            // A stray byte while hunting is ignored by the block, so it does
            // not count toward the stimulus total.
            if ($urandom_range(0, 3) == 0)
                rx_pending.push_back(cfg_start ^ BYTE_W'($urandom_range(1, 255)));
            push_rx(cfg_start);
            if ($urandom_range(0, 4) == 0)
                push_rx(BYTE_W'($urandom_range(int'(cfg_limit) + 1, 255)));
            short_cap = (cfg_limit < 6) ? int'(cfg_limit) : 6;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(0, short_cap);
            else if (pick < 8)
                len = int'(cfg_limit);
            else
                len = $urandom_range(0, int'(cfg_limit));
            push_rx(BYTE_W'(len));
            repeat (len) push_rx(BYTE_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                push_rx(cfg_end ^ BYTE_W'($urandom_range(1, 255)));
            else
                push_rx(cfg_end);
        end
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = stim_count + count;
        while (stim_count < goal)
            queue_frame();
        wait_idle();
    endtask

    initial
    begin : stimulus
        int i;
        rst_n = 1'b0;
        for (i = 0; i < slefp_pkg::MAX_PAYLOAD_DEF; i++)
            store[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames on the reset registers. A byte other than the start
        // marker is skipped while hunting; a length one above the limit, the
        // start marker itself and the largest byte are all refused as
        // lengths; then a zero length closes as an empty frame.
        push_rx(8'h00);
        push_rx(slefp_pkg::START_MARKER_RST);
        push_rx(8'(slefp_pkg::LENGTH_LIMIT_RST) + 8'd1);
        push_rx(slefp_pkg::START_MARKER_RST);
        push_rx(8'hFF);
        push_rx(8'h00);
        push_rx(slefp_pkg::END_MARKER_RST);
        // Short frame whose payload holds both byte extremes.
        push_rx(slefp_pkg::START_MARKER_RST);
        push_rx(8'd2);
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx(slefp_pkg::END_MARKER_RST);
        // Wrong end marker: the frame is dropped without any output.
        push_rx(slefp_pkg::START_MARKER_RST);
        push_rx(8'd1);
        push_rx(8'hA5);
        push_rx(8'h00);
        // Three byte frame with assorted bit patterns.
        push_rx(slefp_pkg::START_MARKER_RST);
        push_rx(8'd3);
        push_rx(8'h5A);
        push_rx(8'h81);
        push_rx(8'h3C);
        push_rx(slefp_pkg::END_MARKER_RST);
        wait_idle();
        run_random(40);

        // Zero markers and the widest length. The upper data bits are set on
        // the limit write, which only keeps its low five bits.
        write_reg(slefp_pkg::REG_START_MARKER, 8'h00);
        write_reg(slefp_pkg::REG_END_MARKER, 8'h00);
        write_reg(slefp_pkg::REG_LENGTH_LIMIT, 8'hFF);
        run_random(50);

        // All-ones start marker and a zero limit: only empty frames pass.
        write_reg(slefp_pkg::REG_START_MARKER, 8'hFF);
        write_reg(slefp_pkg::REG_END_MARKER, 8'h80);
        write_reg(slefp_pkg::REG_LENGTH_LIMIT, 8'h00);
        run_random(30);

        // Random settings, plus a write to the spare index that must not
        // disturb anything.
        write_reg(slefp_pkg::REG_START_MARKER, BYTE_W'($urandom));
        write_reg(slefp_pkg::REG_END_MARKER, BYTE_W'($urandom));
        write_reg(slefp_pkg::REG_LENGTH_LIMIT, BYTE_W'($urandom_range(1, 30)));
        write_reg(REG_SPARE, BYTE_W'($urandom));
        run_random(50);

        // Small limit with junk in the unused upper data bits.
        write_reg(slefp_pkg::REG_START_MARKER, BYTE_W'($urandom));
        write_reg(slefp_pkg::REG_END_MARKER, BYTE_W'($urandom));
        write_reg(slefp_pkg::REG_LENGTH_LIMIT, {3'($urandom), 5'd2});
        run_random(40);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[start_length_end_frame_parser_top.f]
rtl/slefp_pkg.sv
rtl/slefp_ctrl.sv
rtl/slefp_datapath.sv
rtl/start_length_end_frame_parser_top.sv
tb/sv/start_length_end_frame_parser_top_tb.sv
